// ===== hw/rtl/deq_pkg.sv =====
// Shared constants and operation codes for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int OP_W      = 2;

	localparam logic [OP_W-1:0] OP_INS_FRONT = 2'd0;
	localparam logic [OP_W-1:0] OP_INS_BACK  = 2'd1;
	localparam logic [OP_W-1:0] OP_REM_FRONT = 2'd2;
	localparam logic [OP_W-1:0] OP_REM_BACK  = 2'd3;

endpackage

// ===== hw/rtl/deq_mem.sv =====
// Element storage: one write port, one synchronous read port.
`timescale 1ns / 1ps

module deq_mem #(
	parameter int DEPTH  = deq_pkg::DEPTH_DEF,
	parameter int DATA_W = deq_pkg::DATA_W,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [IDX_W-1:0]  waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [IDX_W-1:0]  raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/deq_ctrl.sv =====
// Pointer control, end-value cache and result register of the deque.
`timescale 1ns / 1ps

module deq_ctrl #(
	parameter int DEPTH  = deq_pkg::DEPTH_DEF,
	localparam int DW    = deq_pkg::DATA_W,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int SUM_W = IDX_W + 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [deq_pkg::OP_W-1:0] in_op,
	input  logic [DW-1:0]           in_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [DW-1:0]           out_front,
	output logic [DW-1:0]           out_back,
	output logic [CNT_W-1:0]        out_count,
	output logic                    out_empty,
	output logic                    out_error,
	output logic                    mem_we,
	output logic [IDX_W-1:0]        mem_waddr,
	output logic [DW-1:0]           mem_wdata,
	output logic                    mem_re,
	output logic [IDX_W-1:0]        mem_raddr,
	input  logic [DW-1:0]           mem_rdata
);

	logic [IDX_W-1:0] front_idx_q, front_idx_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [DW-1:0]    fval_q, fval_d, bval_q, bval_d;
	logic             pend_q, pend_d, pend_front_q, pend_front_d;
	logic             out_valid_q;
	logic [DW-1:0]    out_front_q, out_back_q;
	logic [CNT_W-1:0] out_count_q;
	logic             out_error_q;

	logic             accept, out_free, finish, load_out, err_d;
	logic             full, empty;
	logic [SUM_W-1:0] sum_back_ins, sum_back_rem, sum_front_inc;
	logic [IDX_W-1:0] slot_back_ins, slot_back_rem, slot_front_inc, slot_front_dec;

	function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		r = (s >= SUM_W'(DEPTH)) ? s - SUM_W'(DEPTH) : s;
		return r[IDX_W-1:0];
	endfunction

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = !pend_q && out_free;
	assign accept   = in_valid && in_ready;
	assign finish   = pend_q && out_free;

	assign full  = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;

	assign sum_back_ins   = SUM_W'(front_idx_q) + SUM_W'(count_q);
	assign sum_back_rem   = SUM_W'(front_idx_q) + SUM_W'(count_q) - SUM_W'(2);
	assign sum_front_inc  = SUM_W'(front_idx_q) + SUM_W'(1);
	assign slot_back_ins  = wrap(sum_back_ins);
	assign slot_back_rem  = wrap(sum_back_rem);
	assign slot_front_inc = wrap(sum_front_inc);
	assign slot_front_dec = (front_idx_q == '0) ? IDX_W'(DEPTH - 1) : front_idx_q - IDX_W'(1);

	always_comb begin
		front_idx_d  = front_idx_q;
		count_d      = count_q;
		fval_d       = fval_q;
		bval_d       = bval_q;
		pend_d       = pend_q;
		pend_front_d = pend_front_q;
		err_d        = 1'b0;
		load_out     = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = slot_back_ins;
		mem_wdata    = in_value;
		mem_re       = 1'b0;
		mem_raddr    = slot_front_inc;
		if (finish) begin
			pend_d   = 1'b0;
			load_out = 1'b1;
			if (pend_front_q) begin
				fval_d = mem_rdata;
			end else begin
				bval_d = mem_rdata;
			end
		end else if (accept) begin
			load_out = 1'b1;
			case (in_op)
				deq_pkg::OP_INS_FRONT: begin
					if (full) begin
						err_d = 1'b1;
					end else begin
						front_idx_d = slot_front_dec;
						mem_we      = 1'b1;
						mem_waddr   = slot_front_dec;
						count_d     = count_q + CNT_W'(1);
						fval_d      = in_value;
						if (empty) bval_d = in_value;
					end
				end
				deq_pkg::OP_INS_BACK: begin
					if (full) begin
						err_d = 1'b1;
					end else begin
						mem_we    = 1'b1;
						mem_waddr = slot_back_ins;
						count_d   = count_q + CNT_W'(1);
						bval_d    = in_value;
						if (empty) fval_d = in_value;
					end
				end
				deq_pkg::OP_REM_FRONT: begin
					if (empty) begin
						err_d = 1'b1;
					end else begin
						front_idx_d = slot_front_inc;
						count_d     = count_q - CNT_W'(1);
						if (count_q == CNT_W'(2)) begin
							fval_d = bval_q;
						end else if (count_q > CNT_W'(2)) begin
							mem_re       = 1'b1;
							mem_raddr    = slot_front_inc;
							pend_d       = 1'b1;
							pend_front_d = 1'b1;
							load_out     = 1'b0;
						end
					end
				end
				deq_pkg::OP_REM_BACK: begin
					if (empty) begin
						err_d = 1'b1;
					end else begin
						count_d = count_q - CNT_W'(1);
						if (count_q == CNT_W'(2)) begin
							bval_d = fval_q;
						end else if (count_q > CNT_W'(2)) begin
							mem_re       = 1'b1;
							mem_raddr    = slot_back_rem;
							pend_d       = 1'b1;
							pend_front_d = 1'b0;
							load_out     = 1'b0;
						end
					end
				end
				default: begin
					err_d = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_idx_q  <= '0;
			count_q      <= '0;
			pend_q       <= 1'b0;
			pend_front_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			front_idx_q  <= front_idx_d;
			count_q      <= count_d;
			pend_q       <= pend_d;
			pend_front_q <= pend_front_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		fval_q <= fval_d;
		bval_q <= bval_d;
		if (load_out) begin
			out_front_q <= (count_d == '0) ? '0 : fval_d;
			out_back_q  <= (count_d == '0) ? '0 : bval_d;
			out_count_q <= count_d;
			out_error_q <= err_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_front = out_front_q;
	assign out_back  = out_back_q;
	assign out_count = out_count_q;
	assign out_empty = out_count_q == '0;
	assign out_error = out_error_q;

endmodule

// ===== hw/rtl/double_ended_queue_unit.sv =====
// Bounded double-ended queue: requests on s_axis, one result item per request on m_axis.
//
// Each input item carries an operation (insert front, insert back, remove front,
// remove back) and a value; each yields one result item with the front and back
// elements after the operation (zero when empty), the element count, an empty
// flag and an error flag (insert into a full queue or remove from an empty one;
// the state is then left unchanged).
// Elements live in a DEPTH-entry RAM with one write and one registered read port;
// the front and back elements are cached in registers.
// Inserts, errors and removes that leave at most one element load the result register
// directly; removes that must fetch the new front or back first read it from the RAM.
// Throughput: one item per cycle while the output is not stalled; a RAM-fetching remove
// blocks new items until its read completes. The result register decouples the sides:
// a new item is taken while a result waits, unless the result register is still full and
// m_tready is low, or a RAM read is pending. Reset empties the queue at once; no clearing
// pass is needed. While the receiver stalls, the result holds and s_tready drops once a
// further result would have nowhere to go.
`timescale 1ns / 1ps

module double_ended_queue_unit #(
	parameter int DEPTH    = deq_pkg::DEPTH_DEF,
	localparam int DW      = deq_pkg::DATA_W,
	localparam int CNT_W   = $clog2(DEPTH + 1),
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int IN_W    = deq_pkg::OP_W + DW,
	localparam int IN_TW   = ((IN_W + 7) / 8) * 8,
	localparam int RES_W   = 2 * DW + CNT_W + 2,
	localparam int OUT_TW  = ((RES_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_TW-1:0]  s_tdata,  // operation, value
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_TW-1:0] m_tdata   // front_value, back_value, count, empty_res, error
);

	logic [deq_pkg::OP_W-1:0] op;
	logic [DW-1:0]            value;
	logic [DW-1:0]            front_value, back_value;
	logic [CNT_W-1:0]         count;
	logic                     empty_res, error;
	logic                     mem_we, mem_re;
	logic [IDX_W-1:0]         mem_waddr, mem_raddr;
	logic [DW-1:0]            mem_wdata, mem_rdata;

	assign op    = s_tdata[deq_pkg::OP_W-1:0];
	assign value = s_tdata[IN_W-1:deq_pkg::OP_W];

	deq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (op),
		.in_value  (value),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_front (front_value),
		.out_back  (back_value),
		.out_count (count),
		.out_empty (empty_res),
		.out_error (error),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	deq_mem #(
		.DEPTH (DEPTH),
		.DATA_W(DW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign m_tdata = OUT_TW'({error, empty_res, count, back_value, front_value});

endmodule
